[rtl/radial_spotlight_luminance_top_macros.svh]
// Assertion macros used by the radial spotlight RTL (included by rsl_scale).
`ifndef RADIAL_SPOTLIGHT_LUMINANCE_TOP_MACROS_SVH
`define RADIAL_SPOTLIGHT_LUMINANCE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RSL_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsl: check failed");
`define RSL_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsl: check failed");
`else
`define RSL_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RSL_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/rsl_pkg.sv]
// Shared constants and helpers for the radial spotlight luminance block.
package rsl_pkg;

  localparam int COORD_W      = 12;
  localparam int COORD_LIMIT  = 4096;
  localparam int LUM_BITS_DEF = 16;

  localparam int SUM_W   = 2 * COORD_W + 1;
  localparam int ROOT_W  = 16;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;

  localparam int NEAR_SUM_MAX = 25601;

  localparam int FACTOR_W = 17;
  localparam logic [FACTOR_W-1:0] UNITY_FACTOR = 17'd65536;
  localparam logic [FACTOR_W-1:0] FAR_FACTOR   = 17'd13107;
  localparam logic [FACTOR_W-1:0] NEAR_FACTOR_MIN = 17'd13108;

  localparam int SCALED_W  = ROOT_W + 5;
  localparam int DIV_M_W   = 22;
  localparam logic [DIV_M_W-1:0] DIV_M = 22'd2684354;
  localparam int DIV_SHIFT = 26;
  localparam int PROD_W    = SCALED_W + DIV_M_W;
  localparam int QUOT_W    = PROD_W - DIV_SHIFT;
  localparam int DIVISOR   = 25;

  localparam int REG_ADDR_W = 3;
  localparam int DATA_W     = 32;
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] res;
    res = v;
    if (int'(v) >= COORD_LIMIT) begin
      res = COORD_W'(COORD_LIMIT - 1);
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] res;
    if (a >= b) begin
      res = a - b;
    end else begin
      res = b - a;
    end
    return res;
  endfunction

endpackage

[rtl/rsl_dist.sv]
// Distance front end: clamp, absolute offsets, squares and the near test.
module rsl_dist
  import rsl_pkg::*;
#(
  parameter int LUM_BITS = LUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  pixel_col,
  input  logic [COORD_W-1:0]  pixel_row,
  input  logic [LUM_BITS-1:0] lum_in,
  input  logic [COORD_W-1:0]  center_x,
  input  logic [COORD_W-1:0]  center_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RAD_W-1:0]    out_rad,
  output logic                out_near,
  output logic [LUM_BITS-1:0] out_lum
);

  logic                  v1, v2, v3;
  logic                  rdy1, rdy2, rdy3;
  logic [COORD_W-1:0]    dx1, dy1;
  logic [LUM_BITS-1:0]   lum1, lum2, lum3;
  logic [2*COORD_W-1:0]  sqx2, sqy2;
  logic [SUM_W-1:0]      sum;
  logic                  near_next;
  logic [RAD_W-1:0]      rad_next;
  logic [RAD_W-1:0]      rad3;
  logic                  near3;

  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign sum       = {1'b0, sqx2} + {1'b0, sqy2};
  assign near_next = sum <= SUM_W'(NEAR_SUM_MAX);
  assign rad_next  = near_next ? {sum[RAD_W/2-1:0], (RAD_W/2)'(0)} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1  <= abs_diff(clamp_coord(center_x), clamp_coord(pixel_col));
      dy1  <= abs_diff(clamp_coord(center_y), clamp_coord(pixel_row));
      lum1 <= lum_in;
    end
    if (rdy2) begin
      sqx2 <= dx1 * dx1;
      sqy2 <= dy1 * dy1;
      lum2 <= lum1;
    end
    if (rdy3) begin
      rad3  <= rad_next;
      near3 <= near_next;
      lum3  <= lum2;
    end
  end

  assign out_valid = v3;
  assign out_rad   = rad3;
  assign out_near  = near3;
  assign out_lum   = lum3;

endmodule

[rtl/rsl_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module rsl_sqrt
  import rsl_pkg::*;
#(
  parameter int SIDE_W = LUM_BITS_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = ROOT_W;

  logic              vld     [N];
  logic              rdy     [N+1];
  logic [REM_W-1:0]  rem     [N];
  logic [ROOT_W-1:0] root    [N];
  logic [RAD_W-1:0]  rad     [N];
  logic [SIDE_W-1:0] side    [N];
  logic              src_vld [N];
  logic [REM_W-1:0]  src_rem [N];
  logic [ROOT_W-1:0] src_root[N];
  logic [RAD_W-1:0]  src_rad [N];
  logic [SIDE_W-1:0] src_side[N];

  assign rdy[N]   = !out_stall;
  assign in_stall = !rdy[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_vld[k]  = in_valid;
      assign src_rem[k]  = '0;
      assign src_root[k] = '0;
      assign src_rad[k]  = in_rad;
      assign src_side[k] = in_side;
    end else begin : g_rest
      assign src_vld[k]  = vld[k-1];
      assign src_rem[k]  = rem[k-1];
      assign src_root[k] = root[k-1];
      assign src_rad[k]  = rad[k-1];
      assign src_side[k] = side[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];
    assign cur    = {src_rem[k][REM_W-3:0], src_rad[k][RAD_W-1 -: 2]};
    assign trial  = {src_root[k], 2'b01};
    assign ge     = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k]  <= ge ? cur - trial : cur;
        root[k] <= {src_root[k][ROOT_W-2:0], ge};
        rad[k]  <= {src_rad[k][RAD_W-3:0], 2'b00};
        side[k] <= src_side[k];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_root  = root[N-1];
  assign out_side  = side[N-1];

endmodule

[rtl/rsl_scale.sv]
// Factor from distance and luminance scaling.
module rsl_scale
  import rsl_pkg::*;
#(
  parameter int LUM_BITS = LUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROOT_W-1:0]   in_dist,
  input  logic                in_near,
  input  logic [LUM_BITS-1:0] in_lum,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LUM_BITS-1:0] lum_out
);

`include "radial_spotlight_luminance_top_macros.svh"

  logic                         v1, v2, v3;
  logic                         rdy1, rdy2, rdy3;
  logic [SCALED_W-1:0]          scaled;
  logic [SCALED_W-1:0]          x1;
  logic [PROD_W-1:0]            prod1;
  logic                         near1, near2;
  logic [LUM_BITS-1:0]          lum1, lum2;
  logic [QUOT_W-1:0]            q0;
  logic [SCALED_W:0]            rem;
  logic [QUOT_W-1:0]            quot;
  logic [FACTOR_W-1:0]          factor_next;
  logic [FACTOR_W-1:0]          factor2;
  logic [LUM_BITS+FACTOR_W-1:0] product;
  logic [LUM_BITS-1:0]          out3;

  assign rdy3     = !v3 || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign scaled = {in_dist, 5'b00000};

  assign q0   = prod1[PROD_W-1:DIV_SHIFT];
  assign rem  = {1'b0, x1} - (SCALED_W+1)'(q0 * DIVISOR);
  assign quot = (rem >= (SCALED_W+1)'(DIVISOR)) ? q0 + 1'b1 : q0;
  assign factor_next = near1 ? UNITY_FACTOR - FACTOR_W'(quot) : FAR_FACTOR;

  assign product = lum2 * factor2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1    <= scaled;
      prod1 <= scaled * DIV_M;
      near1 <= in_near;
      lum1  <= in_lum;
    end
    if (rdy2) begin
      factor2 <= factor_next;
      near2   <= near1;
      lum2    <= lum1;
    end
    if (rdy3) begin
      out3 <= product[LUM_BITS+15:16];
    end
  end

  assign out_valid = v3;
  assign lum_out   = out3;

  `RSL_ASSERT_IMPL(a_far_zero_dist, clk, rst, v1 && !near1, x1 == '0)
  `RSL_ASSERT_IMPL(a_near_factor_floor, clk, rst, v2 && near2, factor2 >= NEAR_FACTOR_MIN)
  `RSL_ASSERT_NEXT(a_out_not_brighter, clk, rst, v2 && rdy3, out3 <= $past(lum2))

endmodule

[rtl/radial_spotlight_luminance_top.sv]
// Top level of the radial spotlight luminance block with its register port.
//
//  channel  direction  handshake             word
//  pixel    in         in_valid / in_stall   pixel_col, pixel_row, lum_in
//  result   out        out_valid / out_stall lum_out
//  config   in         APB psel/penable      center_x at 0x0, center_y at 0x4
//
// One word per clock while out_stall stays low; the chain has 3 distance stages,
// 16 square-root stages (one root bit each) and 3 factor and multiply stages.
// Synchronous reset clears the stage valid bits and both center registers.
// A stall on the result side holds only the stages that are full; empty
// stages keep filling, and in_stall rises once the whole chain is occupied.
module radial_spotlight_luminance_top
  import rsl_pkg::*;
#(
  parameter int LUM_BITS = LUM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_W-1:0]    pixel_col,
  input  logic [COORD_W-1:0]    pixel_row,
  input  logic [LUM_BITS-1:0]   lum_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LUM_BITS-1:0]   lum_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [COORD_W-1:0]  center_x;
  logic [COORD_W-1:0]  center_y;
  logic                cfg_write;

  logic                d_valid, d_stall;
  logic [RAD_W-1:0]    d_rad;
  logic                d_near;
  logic [LUM_BITS-1:0] d_lum;

  logic                s_valid, s_stall;
  logic [ROOT_W-1:0]   s_root;
  logic [LUM_BITS:0]   s_side;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_write) begin
      unique case (paddr[REG_ADDR_W-1:2])
        REG_CENTER_X: center_x <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: center_y <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_ADDR_W-1:2])
      REG_CENTER_X: prdata = DATA_W'(center_x);
      REG_CENTER_Y: prdata = DATA_W'(center_y);
      default:      prdata = '0;
    endcase
  end

  rsl_dist #(
    .LUM_BITS(LUM_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .lum_in    (lum_in),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .out_rad   (d_rad),
    .out_near  (d_near),
    .out_lum   (d_lum)
  );

  rsl_sqrt #(
    .SIDE_W(LUM_BITS + 1)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_stall  (d_stall),
    .in_rad    (d_rad),
    .in_side   ({d_near, d_lum}),
    .out_valid (s_valid),
    .out_stall (s_stall),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  rsl_scale #(
    .LUM_BITS(LUM_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_stall  (s_stall),
    .in_dist   (s_root),
    .in_near   (s_side[LUM_BITS]),
    .in_lum    (s_side[LUM_BITS-1:0]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lum_out   (lum_out)
  );

endmodule

[tb/tb_radial_spotlight_luminance_top.sv]
// Self-checking testbench for the radial spotlight luminance block.
module tb_radial_spotlight_luminance_top
  import rsl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 100;
  localparam int PHASES       = 6;
  localparam int PRESSURE_PH  = 2;
  localparam int STEADY_PH    = 3;
  localparam int COORD_MAX    = COORD_LIMIT - 1;

  class lum_scoreboard;
    localparam longint unsigned FAR_EDGE_Q8 = 160 * 256;
    localparam longint unsigned FAR_GAIN    = 13107;
    localparam longint unsigned UNITY_GAIN  = 65536;

    bit [COORD_W-1:0] center_col;
    bit [COORD_W-1:0] center_row;
    bit [15:0]        expected_lum[$];
    int               errors;

    function void set_center(logic sel, bit [COORD_W-1:0] coord);
      if (sel == REG_CENTER_Y) begin
        center_row = coord;
      end else begin
        center_col = coord;
      end
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'h4000_0000_0000_0000;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
        if (v >= root + bitpos) begin
          v -= root + bitpos;
          root = (root >> 1) + bitpos;
        end else begin
          root >>= 1;
        end
        bitpos >>= 2;
      end
      return root;
    endfunction

    function bit [15:0] attenuate(bit [COORD_W-1:0] col, bit [COORD_W-1:0] row, bit [15:0] lum);
      longint unsigned dx, dy, dist_q8, gain, prod;
      dx = (center_col >= col) ? center_col - col : col - center_col;
      dy = (center_row >= row) ? center_row - row : row - center_row;
      dist_q8 = root_floor((dx * dx + dy * dy) << 16);
      if (dist_q8 > FAR_EDGE_Q8) begin
        gain = FAR_GAIN;
      end else begin
        gain = UNITY_GAIN - (dist_q8 * 32) / 25;
      end
      prod = longint'(lum) * gain;
      return 16'(prod >> 16);
    endfunction

    function void note_pixel(bit [COORD_W-1:0] col, bit [COORD_W-1:0] row, bit [15:0] lum);
      expected_lum.push_back(attenuate(col, row, lum));
    endfunction

    function void check_result(bit [15:0] actual);
      bit [15:0] want;
      if (expected_lum.size() == 0) begin
        $error("lum_out: no word expected, actual %0d", actual);
        errors++;
      end else begin
        want = expected_lum.pop_front();
        if (actual !== want) begin
          $error("lum_out: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    pixel_col;
  logic [COORD_W-1:0]    pixel_row;
  logic [15:0]           lum_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [15:0]           lum_out;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  lum_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;

  radial_spotlight_luminance_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .lum_in(lum_in),
    .out_valid(out_valid), .out_stall(out_stall), .lum_out(lum_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid && !in_stall) sb.note_pixel(pixel_col, pixel_row, lum_in);
      if (out_valid && !out_stall) sb.check_result(lum_out);
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("** radial_spotlight_luminance_top: FAILED **");
    $finish;
  end

  initial begin
    int hold_left;
    int phase_left;
    int pct;
    hold_left = 0;
    phase_left = 0;
    pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 200);
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 10;
            2: pct = 50;
            default: pct = 80;
          endcase
        end
        phase_left--;
        out_stall = ($urandom_range(99) < pct);
      end
    end
  end

  task automatic send_pixel(input bit [COORD_W-1:0] col, input bit [COORD_W-1:0] row,
                            input bit [15:0] lum);
    pixel_col = col;
    pixel_row = row;
    lum_in = lum;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.expected_lum.size() != 0) @(negedge clk);
  endtask

  task automatic write_center(input logic sel, input bit [COORD_W-1:0] coord);
    logic [DATA_W-1:0] data;
    data = $urandom();
    data[COORD_W-1:0] = coord;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_center(sel, coord);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(coord)) begin
      $error("prdata: expected %0d, actual %0d", coord, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic bit [COORD_W-1:0] nudge(bit [COORD_W-1:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  initial begin
    bit [COORD_W-1:0] cx, cy, col, row;
    bit [15:0] lum;
    int burst_left;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_col = '0;
    pixel_row = '0;
    lum_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // center at reset value
    send_pixel(0, 0, 16'hFFFF);
    send_pixel(0, 0, 16'h0000);
    send_pixel(1, 0, 16'hFFFF);
    send_pixel(160, 0, 16'hFFFF);
    send_pixel(161, 0, 16'hFFFF);
    send_pixel(160, 1, 16'hFFFF);
    send_pixel(96, 128, 16'hFFFF);
    send_pixel(0, 159, 16'h8000);
    send_pixel(COORD_MAX, 0, 16'hFFFF);
    send_pixel(0, COORD_MAX, 16'h5555);
    send_pixel(COORD_MAX, COORD_MAX, 16'hAAAA);
    in_valid = 1'b0;
    drain();
    write_center(REG_CENTER_X, COORD_MAX);
    write_center(REG_CENTER_Y, COORD_MAX);
    send_pixel(COORD_MAX, COORD_MAX, 16'hFFFF);
    send_pixel(COORD_MAX - 160, COORD_MAX, 16'hFFFF);
    send_pixel(COORD_MAX - 96, COORD_MAX - 128, 16'hFFFF);
    send_pixel(COORD_MAX - 100, COORD_MAX - 100, 16'h0001);
    send_pixel(0, 0, 16'hFFFF);
    in_valid = 1'b0;
    drain();
    write_center(REG_CENTER_X, 2048);
    write_center(REG_CENTER_Y, 1000);
    send_pixel(2048, 1000, 16'h1234);
    send_pixel(2048 + 113, 1000 + 113, 16'hFFFF);
    send_pixel(2048 - 80, 1000, 16'hFFFF);
    send_pixel(2048, 1000 - 200, 16'hFFFF);
    in_valid = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin cx = 0; cy = COORD_MAX; end
        1: begin cx = COORD_MAX; cy = 0; end
        2: begin cx = 0; cy = 0; end
        default: begin cx = COORD_W'($urandom()); cy = COORD_W'($urandom()); end
      endcase
      write_center(REG_CENTER_X, cx);
      write_center(REG_CENTER_Y, cy);
      if (p == PRESSURE_PH) hold_req = 1'b1;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          if (p != PRESSURE_PH && p != STEADY_PH && $urandom_range(3) != 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
          end
        end
        burst_left--;
        if ($urandom_range(9) < 7) begin
          col = nudge(cx, 220);
          row = nudge(cy, 220);
        end else begin
          col = COORD_W'($urandom());
          row = COORD_W'($urandom());
        end
        case ($urandom_range(9))
          0: lum = 16'hFFFF;
          1: lum = 16'h0000;
          default: lum = 16'($urandom());
        endcase
        send_pixel(col, row, lum);
      end
      in_valid = 1'b0;
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_lum.size() == 0) begin
      $display("** radial_spotlight_luminance_top: PASSED **");
    end else begin
      $display("** radial_spotlight_luminance_top: FAILED **");
    end
    $finish;
  end

endmodule

[radial_spotlight_luminance_top.f]
+incdir+rtl
rtl/rsl_pkg.sv
rtl/rsl_dist.sv
rtl/rsl_sqrt.sv
rtl/rsl_scale.sv
rtl/radial_spotlight_luminance_top.sv
tb/tb_radial_spotlight_luminance_top.sv
